>>> rtl/core/nde_pkg.sv
// Shared types, codes and arithmetic helpers for the notification dim envelope.
`timescale 1ns / 1ps
`default_nettype none

package nde_pkg;

  // Command codes carried in the func field of an item.
  localparam logic [1:0] FUNC_NOTIFY = 2'd0;
  localparam logic [1:0] FUNC_ENDING = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam int          CFG_IDX_W    = 8;
  localparam logic [7:0]  CFG_FADE_IN  = 8'd0;
  localparam logic [7:0]  CFG_FADE_OUT = 8'd1;
  localparam logic [15:0] FADE_TIME_RESET = 16'd500;

  // Full-scale 8-bit level.
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  // Quotient bits produced by the progress divider.
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic flags;
    logic div_load;
    logic div_sel;
    logic div_step;
    logic store_a;
    logic store_b;
    logic ease_a;
    logic ease_b;
    logic scale;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_env;
    logic out_free;
  } dp_status_t;

  // Fractional 8x8 product, (a*b)>>8.
  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = {8'd0, a} * {8'd0, b};
    return p[15:8];
  endfunction

  // First half of ease-in-out-quad: mirror the upper half onto the lower.
  function automatic logic [7:0] ease_fold(input logic [7:0] i);
    return i[7] ? ~i : i;
  endfunction

  // Second half of ease-in-out-quad from the squared term and the half flag.
  function automatic logic [7:0] ease_finish(input logic [7:0] sq, input logic hi);
    logic [7:0] r;
    r = {sq[6:0], 1'b0};
    return hi ? ~r : r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/nde_ctrl.sv
// Controller state machine that sequences the envelope datapath.
`timescale 1ns / 1ps
`default_nettype none

module nde_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nde_pkg::dp_status_t status,
  output nde_pkg::dp_cmd_t    cmd
);
  import nde_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_FLAGS  = 4'd2;
  localparam logic [3:0] S_LOAD_A = 4'd3;
  localparam logic [3:0] S_DIV_A  = 4'd4;
  localparam logic [3:0] S_LOAD_B = 4'd5;
  localparam logic [3:0] S_DIV_B  = 4'd6;
  localparam logic [3:0] S_EASE_A = 4'd7;
  localparam logic [3:0] S_EASE_B = 4'd8;
  localparam logic [3:0] S_SCALE  = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]           state;
  logic [3:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;
  logic                 cnt_last;

  assign cnt_last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign in_ready = (state == S_IDLE);

  // Next state, step counter and datapath commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.is_env ? S_FLAGS : S_EMIT;
      end
      S_FLAGS: begin
        cmd.flags  = 1'b1;
        state_next = S_LOAD_A;
      end
      S_LOAD_A: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = 1'b0;
        cnt_next     = '0;
        state_next   = S_DIV_A;
      end
      S_DIV_A: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          state_next = S_LOAD_B;
        end
      end
      S_LOAD_B: begin
        cmd.store_a  = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_sel  = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV_B;
      end
      S_DIV_B: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          state_next = S_EASE_A;
        end
      end
      S_EASE_A: begin
        cmd.store_b = 1'b1;
        cmd.ease_a  = 1'b1;
        state_next  = S_EASE_B;
      end
      S_EASE_B: begin
        cmd.ease_b = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nde_datapath.sv
// Datapath: item capture, elapsed time, progress divider, easing, scaling and result.
`timescale 1ns / 1ps
`default_nettype none

module nde_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [nde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          func,
  input  logic [31:0]         now_ms,
  input  logic                background_updated,
  input  logic [7:0]          target_dim,
  input  logic [31:0]         duration_ms,
  input  logic [31:0]         ending_start_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                fade_now,
  output logic [7:0]          fade_amount,
  output logic [7:0]          applied_level,
  input  nde_pkg::dp_cmd_t    cmd,
  output nde_pkg::dp_status_t status
);
  import nde_pkg::*;

  // Configuration registers.
  logic [15:0] fade_in_time;
  logic [15:0] fade_out_time;

  // Persistent state.
  logic        active;
  logic [31:0] start_time;
  logic [7:0]  applied_dim;

  // Captured item.
  logic [1:0]  func_r;
  logic [31:0] now_r;
  logic        redrawn_r;
  logic [7:0]  target_r;
  logic [31:0] duration_r;
  logic [31:0] end_start_r;

  // Working registers.
  logic [31:0] elapsed;
  logic        fin_en;
  logic        fout_en;
  logic [15:0] num_b;
  logic [15:0] div_rem;
  logic [7:0]  div_low;
  logic [7:0]  div_q;
  logic [15:0] div_den;
  logic [7:0]  qa;
  logic [7:0]  qb;
  logic [7:0]  sq_a;
  logic        hi_a;
  logic [7:0]  sq_b;
  logic        hi_b;
  logic [7:0]  level;

  // Combinational terms.
  logic [15:0] div_x;
  logic [23:0] div_num;
  logic [16:0] div_trial;
  logic        div_bit;
  logic [32:0] win_sum;
  logic [7:0]  qb_eff;
  logic [7:0]  fin_v;
  logic [7:0]  fout_v;
  logic [7:0]  env_v;
  logic        is_notify;

  assign is_notify       = (func_r == FUNC_NOTIFY);
  assign status.is_env   = (func_r == FUNC_NOTIFY) || (func_r == FUNC_ENDING);
  assign status.out_free = !out_valid || out_ready;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in_time  <= FADE_TIME_RESET;
      fade_out_time <= FADE_TIME_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FADE_IN) begin
        fade_in_time <= cfg_data;
      end else if (cfg_index == CFG_FADE_OUT) begin
        fade_out_time <= cfg_data;
      end
    end
  end

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r      <= func;
      now_r       <= now_ms;
      redrawn_r   <= background_updated;
      target_r    <= target_dim;
      duration_r  <= duration_ms;
      end_start_r <= ending_start_ms;
    end
  end

  // Fade-out window test without wrap, and the progress numerators.
  assign win_sum = {1'b0, elapsed} + {17'd0, fade_out_time};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (is_notify && !active) begin
        elapsed <= '0;
      end else if (is_notify) begin
        elapsed <= now_r - start_time;
      end else begin
        elapsed <= now_r - end_start_r;
      end
    end
    if (cmd.flags) begin
      fin_en <= (elapsed < {16'd0, fade_in_time});
      if (is_notify) begin
        fout_en <= (duration_r != 32'd0) && (win_sum >= {1'b0, duration_r});
        // The remainder is at most the fade-out time inside the window.
        if (elapsed >= duration_r) begin
          num_b <= '0;
        end else begin
          num_b <= 16'(duration_r - elapsed);
        end
      end else begin
        fout_en <= (elapsed < {16'd0, fade_out_time});
        num_b   <= elapsed[15:0];
      end
    end
  end

  // Restoring divider for x*255/len; the quotient is known to fit 8 bits,
  // so the top 16 numerator bits start below the divisor.
  assign div_x     = cmd.div_sel ? num_b : elapsed[15:0];
  assign div_num   = {div_x, 8'd0} - {8'd0, div_x};
  assign div_trial = {div_rem, div_low[7]};
  assign div_bit   = (div_trial >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem <= div_num[23:8];
      div_low <= div_num[7:0];
      div_den <= cmd.div_sel ? fade_out_time : fade_in_time;
      div_q   <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_bit ? 16'(div_trial - {1'b0, div_den}) : div_trial[15:0];
      div_low <= {div_low[6:0], 1'b0};
      div_q   <= {div_q[6:0], div_bit};
    end
    if (cmd.store_a) begin
      qa <= div_q;
    end
    if (cmd.store_b) begin
      qb <= div_q;
    end
  end

  // Easing squares, one multiplier result registered per step.
  assign qb_eff = (fade_out_time == 16'd0) ? 8'd0 : qb;

  always_ff @(posedge clk) begin
    if (cmd.ease_a) begin
      sq_a <= scale8(ease_fold(qa), ease_fold(qa));
      hi_a <= qa[7];
    end
    if (cmd.ease_b) begin
      sq_b <= scale8(ease_fold(qb_eff), ease_fold(qb_eff));
      hi_b <= qb_eff[7];
    end
  end

  // Envelope: lower of fade-in and fade-out, or the ending fade-out.
  always_comb begin
    fin_v = fin_en ? ease_finish(sq_a, hi_a) : LEVEL_MAX;
    if (is_notify) begin
      fout_v = fout_en ? ease_finish(sq_b, hi_b) : LEVEL_MAX;
      env_v  = (fin_v < fout_v) ? fin_v : fout_v;
    end else begin
      fout_v = fout_en ? ~ease_finish(sq_b, hi_b) : 8'd0;
      env_v  = fout_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      level <= scale8(target_r, env_v);
    end
  end

  // Persistent state: start latch on first notify item, applied level.
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      start_time  <= '0;
      applied_dim <= '0;
    end else begin
      if (cmd.prep && is_notify && !active) begin
        active      <= 1'b1;
        start_time  <= now_r;
        applied_dim <= '0;
      end
      if (cmd.emit) begin
        if (func_r == FUNC_CLEAR) begin
          active      <= 1'b0;
          applied_dim <= '0;
        end else if (status.is_env && (redrawn_r || (level > applied_dim))) begin
          applied_dim <= level;
        end
      end
    end
  end

  // Output register for the result item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (func_r == FUNC_CLEAR) begin
        fade_now      <= 1'b0;
        fade_amount   <= '0;
        applied_level <= '0;
      end else if (!status.is_env) begin
        fade_now      <= 1'b0;
        fade_amount   <= '0;
        applied_level <= applied_dim;
      end else if (redrawn_r) begin
        fade_now      <= 1'b1;
        fade_amount   <= level;
        applied_level <= level;
      end else if (level <= applied_dim) begin
        fade_now      <= 1'b0;
        fade_amount   <= '0;
        applied_level <= applied_dim;
      end else begin
        fade_now      <= 1'b1;
        fade_amount   <= level - applied_dim;
        applied_level <= level;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/notification_dim_envelope_core.sv
// Top level of the notification dim envelope: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one frame command at a time and returns one result item per
// command. A notification or ending frame passes through prepare, flags, two
// divider runs, easing, scaling and emit; a clear or unused command goes from
// prepare straight to emit. Emit waits while the output register holds an
// untaken result, and the block is ready for the next item in the cycle after
// the emit. The progress divider is an 8-step restoring unit that is run twice
// per frame (fade-in, then fade-out). The result sits in an output register,
// so the next item is taken while the previous one waits. The configuration
// port is always ready and should only be written while the block is idle.
module notification_dim_envelope_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [nde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] now_ms,
  input  logic        background_updated,
  input  logic [7:0]  target_dim,
  input  logic [31:0] duration_ms,
  input  logic [31:0] ending_start_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        fade_now,
  output logic [7:0]  fade_amount,
  output logic [7:0]  applied_level
);
  import nde_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer.
  nde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  nde_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .func               (func),
    .now_ms             (now_ms),
    .background_updated (background_updated),
    .target_dim         (target_dim),
    .duration_ms        (duration_ms),
    .ending_start_ms    (ending_start_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .fade_now           (fade_now),
    .fade_amount        (fade_amount),
    .applied_level      (applied_level),
    .cmd                (cmd),
    .status             (status)
  );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the notification dim envelope core.
`timescale 1ns / 1ps

module testbench;
  import nde_pkg::*;

  // Command code with no function; the block must leave its state alone.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // One frame command as the driver presents it.
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic        background_updated;
    logic [7:0]  target_dim;
    logic [31:0] duration_ms;
    logic [31:0] ending_start_ms;
  } frame_t;

  // One dimming result as the block returns it.
  typedef struct packed {
    logic       fade_now;
    logic [7:0] fade_amount;
    logic [7:0] applied_level;
  } dim_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [31:0] now_ms = '0;
  logic        background_updated = 1'b0;
  logic [7:0]  target_dim = '0;
  logic [31:0] duration_ms = '0;
  logic [31:0] ending_start_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        fade_now;
  logic [7:0]  fade_amount;
  logic [7:0]  applied_level;

  notification_dim_envelope_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .now_ms(now_ms),
    .background_updated(background_updated),
    .target_dim(target_dim),
    .duration_ms(duration_ms),
    .ending_start_ms(ending_start_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fade_now(fade_now),
    .fade_amount(fade_amount),
    .applied_level(applied_level)
  );

  always #10 clk = ~clk;

  // Envelope state and fade settings mirrored by the predictor.
  logic        env_active = 1'b0;
  logic [31:0] env_start = '0;
  logic [7:0]  env_applied = '0;
  logic [15:0] ramp_in_len = FADE_TIME_RESET;
  logic [15:0] ramp_out_len = FADE_TIME_RESET;

  frame_t      frame_pending[$];
  dim_result_t dim_expected[$];
  int          err_cnt = 0;

  // Fractional 8x8 product that keeps the upper byte.
  function automatic logic [7:0] frac_mul(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = {8'd0, a} * {8'd0, b};
    return p[15:8];
  endfunction

  // Quadratic ease-in-out on an 8-bit phase.
  function automatic logic [7:0] ease_curve(input logic [7:0] x);
    logic [7:0] m;
    logic [7:0] sq;
    logic [7:0] r;
    m = x[7] ? 8'd255 - x : x;
    sq = frac_mul(m, m);
    r = {sq[6:0], 1'b0};
    if (x[7]) begin
      r = 8'd255 - r;
    end
    return r;
  endfunction

  // Elapsed time as a fraction of a fade length, in 1/255 steps, clamped.
  function automatic logic [7:0] ramp(input logic [31:0] t, input logic [15:0] len);
    logic [39:0] q;
    if (len == 16'd0) begin
      return 8'd0;
    end
    q = ({8'd0, t} * 40'd255) / {24'd0, len};
    return (q > 40'd255) ? 8'd255 : q[7:0];
  endfunction

  // Turns a dim level into a fade command against what is already applied.
  function automatic dim_result_t apply_level(input logic [7:0] lvl, input logic redrawn);
    dim_result_t r;
    if (redrawn) begin
      env_applied = lvl;
      r.fade_now = 1'b1;
      r.fade_amount = lvl;
      r.applied_level = lvl;
    end else if (lvl <= env_applied) begin
      r.fade_now = 1'b0;
      r.fade_amount = 8'd0;
      r.applied_level = env_applied;
    end else begin
      r.fade_now = 1'b1;
      r.fade_amount = lvl - env_applied;
      r.applied_level = lvl;
      env_applied = lvl;
    end
    return r;
  endfunction

  // Expected result of one frame command, advancing the mirrored state.
  function automatic dim_result_t dim_for_frame(input frame_t f);
    dim_result_t r;
    logic [31:0] elapsed;
    logic [31:0] rem;
    logic [7:0]  fin;
    logic [7:0]  fout;
    case (f.func)
      FUNC_NOTIFY: begin
        if (!env_active) begin
          env_active = 1'b1;
          env_start = f.now_ms;
          env_applied = 8'd0;
        end
        elapsed = f.now_ms - env_start;
        fin = 8'd255;
        fout = 8'd255;
        if (elapsed < {16'd0, ramp_in_len}) begin
          fin = ease_curve(ramp(elapsed, ramp_in_len));
        end
        // The window test is done on 33 bits so that it cannot wrap.
        if (f.duration_ms != 32'd0 &&
            ({1'b0, elapsed} + {17'd0, ramp_out_len}) >= {1'b0, f.duration_ms}) begin
          rem = (elapsed >= f.duration_ms) ? 32'd0 : f.duration_ms - elapsed;
          fout = ease_curve(ramp(rem, ramp_out_len));
        end
        r = apply_level(frac_mul(f.target_dim, (fin < fout) ? fin : fout),
                        f.background_updated);
      end
      FUNC_ENDING: begin
        elapsed = f.now_ms - f.ending_start_ms;
        fout = 8'd0;
        if (elapsed < {16'd0, ramp_out_len}) begin
          fout = 8'd255 - ease_curve(ramp(elapsed, ramp_out_len));
        end
        r = apply_level(frac_mul(f.target_dim, fout), f.background_updated);
      end
      default: begin
        if (f.func == FUNC_CLEAR) begin
          env_active = 1'b0;
          env_applied = 8'd0;
        end
        r.fade_now = 1'b0;
        r.fade_amount = 8'd0;
        r.applied_level = env_applied;
      end
    endcase
    return r;
  endfunction

  // Input driver: one item at a time from the pending queue, with random gaps.
  logic   drv_fire;
  logic   drv_calm = 1'b0;
  int     gap_left = 0;
  frame_t cur_frame;

  always @(posedge clk) begin
    drv_fire = in_valid && in_ready;
    if (drv_fire) begin
      dim_expected.push_back(dim_for_frame(cur_frame));
    end
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || drv_fire) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (frame_pending.size() != 0) begin
        cur_frame = frame_pending.pop_front();
        func <= cur_frame.func;
        now_ms <= cur_frame.now_ms;
        background_updated <= cur_frame.background_updated;
        target_dim <= cur_frame.target_dim;
        duration_ms <= cur_frame.duration_ms;
        ending_start_ms <= cur_frame.ending_start_ms;
        in_valid <= 1'b1;
        if ($urandom_range(0, 29) == 0) begin
          drv_calm = !drv_calm;
        end
        gap_left <= drv_calm ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Reports one field that differs from its expectation.
  function automatic void note_mismatch(input string name, input int want, input int got);
    err_cnt++;
    $error("%s mismatch: expected %0d, got %0d", name, want, got);
  endfunction

  // Output monitor: random stalls on out_ready, and a field-by-field check.
  logic        mon_take;
  logic        mon_calm = 1'b0;
  int          mon_draw;
  int          stall_left = 0;
  dim_result_t want;

  always @(posedge clk) begin
    mon_take = out_valid && out_ready;
    if (mon_take) begin
      if (dim_expected.size() == 0) begin
        err_cnt++;
        $error("result with no item outstanding: fade_now %0d fade_amount %0d level %0d",
               fade_now, fade_amount, applied_level);
      end else begin
        want = dim_expected.pop_front();
        if (fade_now !== want.fade_now) begin
          note_mismatch("fade_now", int'(want.fade_now), int'(fade_now));
        end
        if (fade_amount !== want.fade_amount) begin
          note_mismatch("fade_amount", int'(want.fade_amount), int'(fade_amount));
        end
        if (applied_level !== want.applied_level) begin
          note_mismatch("applied_level", int'(want.applied_level), int'(applied_level));
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (mon_take) begin
      if ($urandom_range(0, 29) == 0) begin
        mon_calm = !mon_calm;
      end
      mon_draw = mon_calm ? 0 : $urandom_range(0, 13);
      stall_left <= mon_draw;
      out_ready <= (mon_draw == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Writes one fade register and mirrors it once the write is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FADE_IN: ramp_in_len = val;
      CFG_FADE_OUT: ramp_out_len = val;
      default: ;
    endcase
  endtask

  // Waits until every item is taken and every result is back, then some more.
  task automatic drain_block(input int tail);
    while (frame_pending.size() != 0 || in_valid || dim_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (tail) @(negedge clk);
  endtask

  task automatic queue_frame(input logic [1:0] fn, input logic [31:0] now,
                             input logic bg, input logic [7:0] tgt,
                             input logic [31:0] dur, input logic [31:0] es);
    frame_t f;
    f.func = fn;
    f.now_ms = now;
    f.background_updated = bg;
    f.target_dim = tgt;
    f.duration_ms = dur;
    f.ending_start_ms = es;
    frame_pending.push_back(f);
  endtask

  // A notification lifetime: an optional clear, rising frames, fade-out, ending frames.
  task automatic queue_envelope_run(input int unsigned fin, input int unsigned fout);
    int unsigned span;
    int unsigned n;
    int unsigned m;
    int unsigned stepmax;
    int unsigned endstep;
    logic [31:0] t;
    logic [31:0] es;
    logic [31:0] dur;
    logic [7:0]  tgt;
    span = fin + fout + 4;
    n = $urandom_range(4, 16);
    stepmax = (2 * span) / n + 1;
    tgt = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: dur = 32'd0;
      1: dur = $urandom;
      default: dur = $urandom_range(1, 2 * span);
    endcase
    t = $urandom;
    if ($urandom_range(0, 5) != 0) begin
      queue_frame(FUNC_CLEAR, t, 1'($urandom_range(0, 1)), 8'($urandom), $urandom, $urandom);
    end
    for (int k = 0; k < n; k++) begin
      t = t + $urandom_range(0, stepmax);
      if ($urandom_range(0, 11) == 0) begin
        t = t - $urandom_range(1, stepmax);
      end
      queue_frame(FUNC_NOTIFY, t, $urandom_range(0, 3) == 0, tgt, dur, $urandom);
    end
    es = t + $urandom_range(0, stepmax);
    m = $urandom_range(0, 6);
    endstep = (2 * fout + 4) / (m + 1) + 1;
    t = es;
    for (int k = 0; k < m; k++) begin
      t = t + $urandom_range(0, endstep);
      queue_frame(FUNC_ENDING, ($urandom_range(0, 9) == 0) ? es - 1 : t,
                  $urandom_range(0, 3) == 0, tgt, $urandom, es);
    end
  endtask

  // Random part of a phase: mostly whole lifetimes, some loose noise.
  task automatic queue_random(input int count);
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_frame(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                    8'($urandom), $urandom, $urandom);
        made = made + 1;
      end else begin
        made = made - frame_pending.size();
        queue_envelope_run({16'd0, ramp_in_len}, {16'd0, ramp_out_len});
        made = made + frame_pending.size();
      end
    end
  endtask

  // Stimulus: directed frames on the reset settings, then phases of settings.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Latching, fade-in, wrapped time, fade-out window and its wide sum.
    queue_frame(FUNC_CLEAR, 32'd0, 1'b0, 8'd0, 32'd0, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd1000, 1'b1, 8'd255, 32'd0, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd1250, 1'b0, 8'd255, 32'd0, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd1200, 1'b0, 8'd255, 32'd0, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd999, 1'b0, 8'd255, 32'd0, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd1600, 1'b1, 8'd128, 32'd900, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd2000, 1'b0, 8'd255, 32'd500, 32'hFFFF_FFFF);
    queue_frame(FUNC_NOTIFY, 32'd999, 1'b1, 8'd255, 32'hFFFF_FFFF, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd500, 1'b0, 8'd200, 32'hFFFF_FFFF, 32'd0);
    // Ending frames, inside and past the fade-out, and with wrapped time.
    queue_frame(FUNC_ENDING, 32'd5100, 1'b1, 8'd255, 32'd0, 32'd5000);
    queue_frame(FUNC_ENDING, 32'd5600, 1'b0, 8'd255, 32'd0, 32'd5000);
    queue_frame(FUNC_ENDING, 32'd4999, 1'b0, 8'd255, 32'd0, 32'd5000);
    queue_frame(FUNC_ENDING, 32'hFFFF_FFFF, 1'b1, 8'd255, 32'hFFFF_FFFF, 32'd0);
    queue_frame(FUNC_UNUSED, 32'h5A5A_A5A5, 1'b1, 8'd255, 32'd1, 32'd1);
    queue_frame(FUNC_NOTIFY, 32'd3000, 1'b1, 8'd0, 32'd0, 32'd0);
    // A clear, then a new start near the top of the time range.
    queue_frame(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b1, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_frame(FUNC_UNUSED, 32'd0, 1'b0, 8'd0, 32'd0, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'hFFFF_FFFF, 1'b0, 8'd255, 32'd1, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'h0000_0100, 1'b0, 8'd255, 32'd0, 32'd0);
    queue_frame(FUNC_ENDING, 32'd100, 1'b0, 8'hAA, 32'd0, 32'd0);
    queue_frame(FUNC_CLEAR, 32'd0, 1'b0, 8'd0, 32'd0, 32'd0);
    drain_block(30);

    // Zero fade lengths: instant fade-in, fade-out progress taken as zero.
    write_reg(CFG_FADE_IN, 16'd0);
    write_reg(CFG_FADE_OUT, 16'd0);
    @(negedge clk);
    queue_frame(FUNC_CLEAR, 32'd0, 1'b0, 8'd0, 32'd0, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd77, 1'b1, 8'd255, 32'd0, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd80, 1'b0, 8'd200, 32'd10, 32'd0);
    queue_frame(FUNC_NOTIFY, 32'd90, 1'b1, 8'd200, 32'd10, 32'd0);
    queue_frame(FUNC_ENDING, 32'd90, 1'b1, 8'd255, 32'd0, 32'd90);
    queue_random(120);

    // Phases over extreme, mixed and random fade lengths, ending on the defaults.
    for (int p = 0; p < 7; p++) begin
      drain_block(30);
      case (p)
        0: begin
          write_reg(CFG_FADE_IN, 16'd1);
          write_reg(CFG_FADE_OUT, 16'd1);
        end
        1: begin
          write_reg(CFG_FADE_IN, 16'hFFFF);
          write_reg(CFG_FADE_OUT, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_FADE_IN, 16'd1);
          write_reg(CFG_FADE_OUT, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_FADE_IN, 16'hFFFF);
          write_reg(CFG_FADE_OUT, 16'd1);
        end
        4: begin
          write_reg(CFG_FADE_IN, 16'($urandom_range(1, 65535)));
          write_reg(CFG_FADE_OUT, 16'($urandom_range(1, 65535)));
        end
        5: begin
          write_reg(CFG_FADE_IN, 16'($urandom_range(2, 2000)));
          write_reg(CFG_FADE_OUT, 16'($urandom_range(2, 2000)));
        end
        default: begin
          write_reg(CFG_FADE_IN, FADE_TIME_RESET);
          write_reg(CFG_FADE_OUT, FADE_TIME_RESET);
        end
      endcase
      @(negedge clk);
      queue_random(180);
    end

    drain_block(60);
    if (dim_expected.size() != 0) begin
      err_cnt = err_cnt + dim_expected.size();
      $error("%0d expected results never arrived", dim_expected.size());
    end
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(600000 * 20);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
